// ===== sv/spr_pkg.sv =====
// Package for the shortest path reach counter: payload structs, command codes,
// node and cost constants, and the controller/datapath command and status structs.
// No dependencies.
package spr_pkg;

  localparam int MAX_NODES         = 64;
  localparam int NODE_BITS         = 6;
  localparam int NODE_CNT_BITS     = 7;
  localparam int COST_BITS         = 23;
  localparam int WEIGHT_FIELD_BITS = 16;
  localparam int THRESHOLD_BITS    = 22;

  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0]                   command;
    logic [NODE_BITS-1:0]         edge_from;
    logic [NODE_BITS-1:0]         edge_to;
    logic [WEIGHT_FIELD_BITS-1:0] edge_weight;
    logic [NODE_BITS-1:0]         source_node;
    logic [THRESHOLD_BITS-1:0]    threshold;
  } in_item_t;

  typedef struct packed {
    logic [NODE_CNT_BITS-1:0] reached_count;
    logic                     edges_dropped;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_edges;
    logic add_edge;
    logic run_init;
    logic scan_issue;
    logic mark_done;
    logic edge_step;
    logic cost_upd;
    logic count_issue;
    logic out_load;
  } spr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic node_last;
    logic best_found;
    logic best_inf;
    logic edge_none;
    logic edge_match;
    logic edge_last;
  } spr_status_t;

endpackage

// ===== sv/shortest_path_reach_counter.sv =====
// Shortest path reach counter. Clear and add-edge items are taken back to back, without stalling.
// A run repeats a linear minimum scan over the nodes in use and a relax pass over the
// stored edges for each selected node, then counts the nodes within the threshold;
// the result then waits for any stalled earlier result to be transferred.
// Synchronous reset clears the edge count and drop flag and sets nodes_in_use to 64;
// no clearing pass.
module shortest_path_reach_counter #(
  parameter int MAX_EDGES   = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  spr_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output spr_pkg::out_item_t                out_data,
  input  logic                              cfg_write,
  input  logic [spr_pkg::NODE_CNT_BITS-1:0] cfg_data
);
  import spr_pkg::*;

  spr_cmd_t    cmd;
  spr_status_t status;

  spr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (in_data.command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  spr_datapath #(
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== sv/spr_ctrl.sv =====
// Controller for the shortest path reach counter: sequences scan, relax and
// count phases and owns the output valid flag.
// Depends on spr_pkg.
module spr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  output logic                out_valid,
  input  logic                out_stall,
  output spr_pkg::spr_cmd_t   cmd,
  input  spr_pkg::spr_status_t status
);
  import spr_pkg::*;

  typedef enum logic [3:0] {
    IDLE, SCAN, SCAN_TAIL, PICK, E_CHK, E_UPD, CNT, CNT_TAIL, FIN
  } state_t;

  state_t state, state_next;
  logic   in_xfer;

  assign in_stall = (state != IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (in_xfer) begin
          unique case (command)
            CMD_CLEAR: cmd.clear_edges = 1'b1;
            CMD_ADD:   cmd.add_edge = 1'b1;
            CMD_RUN: begin
              cmd.run_init = 1'b1;
              state_next   = SCAN;
            end
            default: ;
          endcase
        end
      end
      SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.node_last) state_next = SCAN_TAIL;
      end
      SCAN_TAIL: state_next = PICK;
      PICK: begin
        if (!status.best_found || status.best_inf) begin
          state_next = CNT;
        end else begin
          cmd.mark_done = 1'b1;
          state_next    = status.edge_none ? SCAN : E_CHK;
        end
      end
      E_CHK: begin
        if (status.edge_match) begin
          state_next = E_UPD;
        end else begin
          cmd.edge_step = 1'b1;
          if (status.edge_last) state_next = SCAN;
        end
      end
      E_UPD: begin
        cmd.cost_upd  = 1'b1;
        cmd.edge_step = 1'b1;
        state_next    = status.edge_last ? SCAN : E_CHK;
      end
      CNT: begin
        cmd.count_issue = 1'b1;
        if (status.node_last) state_next = CNT_TAIL;
      end
      CNT_TAIL: state_next = FIN;
      FIN: begin
        // hold the result until the previous one has been transferred
        if (!(out_valid && out_stall)) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/spr_datapath.sv =====
// Datapath for the shortest path reach counter: edge store, cost memory,
// visited bits, minimum tracker, relax adder and reach counter.
// Depends on spr_pkg; driven by spr_ctrl.
module spr_datapath #(
  parameter int MAX_EDGES   = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  spr_pkg::spr_cmd_t     cmd,
  input  spr_pkg::in_item_t     in_data,
  input  logic                  cfg_write,
  input  logic [spr_pkg::NODE_CNT_BITS-1:0] cfg_data,
  output spr_pkg::spr_status_t  status,
  output spr_pkg::out_item_t    out_data
);
  import spr_pkg::*;

  localparam int WB = (WEIGHT_BITS < WEIGHT_FIELD_BITS) ? WEIGHT_BITS : WEIGHT_FIELD_BITS;
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET = $clog2(MAX_EDGES + 1);

  typedef struct packed {
    logic [NODE_BITS-1:0] tail;
    logic [NODE_BITS-1:0] head;
    logic [WB-1:0]        weight;
  } edge_t;

  // configuration and edge bookkeeping
  logic [NODE_CNT_BITS-1:0] nodes_in_use;
  logic [NODE_CNT_BITS-1:0] n_eff;
  logic [ET-1:0]            edge_total;
  logic                     drop_flag;
  logic                     add_ok;

  // edge store
  edge_t                    edge_mem [MAX_EDGES];
  edge_t                    edge_q;
  logic [ET-1:0]            edge_idx, edge_idx_next;

  // cost store; valid bit clear reads as infinity
  logic [COST_BITS-1:0]     cost_mem [MAX_NODES];
  logic [MAX_NODES-1:0]     cost_valid;
  logic [MAX_NODES-1:0]     node_done;
  logic [COST_BITS-1:0]     cost_q;
  logic                     cost_vq;
  logic [COST_BITS-1:0]     cost_eff;
  logic [NODE_BITS-1:0]     cost_ra;
  logic [NODE_BITS-1:0]     cost_wa;
  logic [COST_BITS-1:0]     cost_wd;
  logic                     cost_we;

  // scan and count sequencing
  logic [NODE_CNT_BITS-1:0] node_idx;
  logic                     s_v, c_v;
  logic [NODE_BITS-1:0]     s_idx;
  logic                     best_found;
  logic [COST_BITS-1:0]     best_cost;
  logic [NODE_BITS-1:0]     best_idx;
  logic                     cand;
  logic [THRESHOLD_BITS-1:0] limit;
  logic [NODE_CNT_BITS-1:0] count;

  logic                     src_ok;
  logic [MAX_NODES-1:0]     src_onehot;
  logic [COST_BITS:0]       sum_raw;
  logic [COST_BITS-1:0]     relax_cost;

  always_comb begin
    if (nodes_in_use == '0) begin
      n_eff = NODE_CNT_BITS'(1);
    end else if (nodes_in_use > NODE_CNT_BITS'(MAX_NODES)) begin
      n_eff = NODE_CNT_BITS'(MAX_NODES);
    end else begin
      n_eff = nodes_in_use;
    end
  end

  assign add_ok = (edge_total != ET'(MAX_EDGES))
               && ({1'b0, in_data.edge_from} < n_eff)
               && ({1'b0, in_data.edge_to} < n_eff);
  assign src_ok = {1'b0, in_data.source_node} < n_eff;
  assign src_onehot = src_ok ? (MAX_NODES'(1) << in_data.source_node) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_in_use <= NODE_CNT_BITS'(MAX_NODES);
      edge_total   <= '0;
      drop_flag    <= 1'b0;
    end else begin
      if (cfg_write) nodes_in_use <= cfg_data;
      if (cmd.clear_edges) begin
        edge_total <= '0;
        drop_flag  <= 1'b0;
      end else if (cmd.add_edge) begin
        if (add_ok) edge_total <= edge_total + ET'(1);
        else        drop_flag  <= 1'b1;
      end
    end
  end

  // edge index; the store is read at the next index so edge_q tracks edge_idx
  always_comb begin
    edge_idx_next = edge_idx;
    if (cmd.mark_done) begin
      edge_idx_next = '0;
    end else if (cmd.edge_step) begin
      edge_idx_next = status.edge_last ? '0 : edge_idx + ET'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) edge_idx <= '0;
    else     edge_idx <= edge_idx_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.add_edge && add_ok) begin
      edge_mem[edge_total[EA-1:0]] <= '{tail:   in_data.edge_from,
                                        head:   in_data.edge_to,
                                        weight: in_data.edge_weight[WB-1:0]};
    end
    edge_q <= edge_mem[edge_idx_next[EA-1:0]];
  end

  // relax: saturating sum against the registered cost of the edge head
  assign sum_raw    = {1'b0, best_cost} + (COST_BITS+1)'(edge_q.weight);
  assign relax_cost = sum_raw[COST_BITS] ? COST_INF : sum_raw[COST_BITS-1:0];
  assign cost_eff   = cost_vq ? cost_q : COST_INF;

  always_comb begin
    cost_ra = (cmd.scan_issue || cmd.count_issue) ? node_idx[NODE_BITS-1:0] : edge_q.head;
    cost_we = 1'b0;
    cost_wa = edge_q.head;
    cost_wd = relax_cost;
    if (cmd.run_init) begin
      cost_we = src_ok;
      cost_wa = in_data.source_node;
      cost_wd = '0;
    end else if (cmd.cost_upd) begin
      cost_we = relax_cost < cost_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_q <= cost_mem[cost_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_valid <= '0;
      node_done  <= '0;
      cost_vq    <= 1'b0;
    end else begin
      cost_vq <= cost_valid[cost_ra];
      if (cmd.run_init) begin
        node_done  <= '0;
        cost_valid <= src_onehot;
      end else begin
        if (cost_we)       cost_valid[cost_wa] <= 1'b1;
        if (cmd.mark_done) node_done[best_idx] <= 1'b1;
      end
    end
  end

  // node index shared by the minimum scan and the final count
  always_ff @(posedge clk) begin
    if (rst) begin
      node_idx <= '0;
      s_v      <= 1'b0;
      c_v      <= 1'b0;
    end else begin
      s_v <= cmd.scan_issue;
      c_v <= cmd.count_issue;
      if (cmd.run_init) begin
        node_idx <= '0;
      end else if (cmd.scan_issue || cmd.count_issue) begin
        node_idx <= status.node_last ? '0 : node_idx + NODE_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s_idx <= node_idx[NODE_BITS-1:0];
  end

  // strict compare keeps the lowest index on ties
  assign cand = !node_done[s_idx] && (!best_found || (cost_eff < best_cost));

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (cmd.scan_issue && (node_idx == '0)) begin
      best_found <= 1'b0;
    end else if (s_v && cand) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_v && cand) begin
      best_cost <= cost_eff;
      best_idx  <= s_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      limit <= in_data.threshold;
      count <= '0;
    end else if (c_v && (cost_eff <= {1'b0, limit})) begin
      count <= count + NODE_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.reached_count <= count;
      out_data.edges_dropped <= drop_flag;
    end
  end

  always_comb begin
    status.node_last  = node_idx == (n_eff - NODE_CNT_BITS'(1));
    status.best_found = best_found;
    status.best_inf   = best_cost == COST_INF;
    status.edge_none  = edge_total == '0;
    status.edge_match = (edge_q.tail == best_idx) && ({1'b0, edge_q.head} < n_eff);
    status.edge_last  = edge_idx == (edge_total - ET'(1));
  end

endmodule

// ===== sv/spr_checker.sv =====
// Port-level checks for the shortest path reach counter, bound to the top level.
// Depends on spr_pkg.
module spr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input spr_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input spr_pkg::out_item_t out_data
);
  import spr_pkg::*;

  // a pending result holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // clear, add and unused codes leave the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.command != CMD_RUN) |=> !in_stall)
    else $error("input stalled after a load transfer");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.command == CMD_RUN) |=> in_stall)
    else $error("input not stalled after a run transfer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.reached_count <= NODE_CNT_BITS'(MAX_NODES))
    else $error("reached count above node capacity");

  // a result appears only as a run finishes
  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a run");

endmodule

bind shortest_path_reach_counter spr_checker u_spr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_shortest_path_reach_counter.sv =====
// Testbench for shortest_path_reach_counter: directed and random edge loads and searches,
// checked against an in-bench shortest-path predictor with random gaps on both channels.
// Depends on spr_pkg and shortest_path_reach_counter.
`timescale 1ns / 100ps

module tb_shortest_path_reach_counter;
  import spr_pkg::*;

  localparam int         LINK_CAP   = 256;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk;
  logic      rst;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_write;
  logic [NODE_CNT_BITS-1:0] cfg_data;

  // predictor copy of the block state
  logic [NODE_BITS-1:0]         link_tail   [LINK_CAP];
  logic [NODE_BITS-1:0]         link_head   [LINK_CAP];
  logic [WEIGHT_FIELD_BITS-1:0] link_weight [LINK_CAP];
  int                           link_count = 0;
  logic                         drop_seen  = 1'b0;
  logic [NODE_CNT_BITS-1:0]     node_limit = 7'd64;

  in_item_t  item_q  [$];
  out_item_t reach_q [$];
  int        pushed_total   = 0;
  int        accepted_total = 0;
  int        stim_count     = 0;
  int        mismatch_count = 0;
  logic      in_done = 1'b0;
  bit        quiet   = 1'b0;

  shortest_path_reach_counter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int active_node_count();
    if (node_limit == 0) return 1;
    if (node_limit > MAX_NODES) return MAX_NODES;
    return node_limit;
  endfunction

  // linear-scan Dijkstra over the stored links, then count costs within thr
  function automatic logic [NODE_CNT_BITS-1:0] count_reached(
    input logic [NODE_BITS-1:0] src, input logic [THRESHOLD_BITS-1:0] thr);
    logic [COST_BITS-1:0] cost [MAX_NODES];
    bit                   settled [MAX_NODES];
    logic [COST_BITS:0]   sum;
    int                   n;
    int                   best;
    int                   hits;
    bit                   progress;
    n = active_node_count();
    hits = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      cost[i] = COST_INF;
      settled[i] = 1'b0;
    end
    if (src < n) cost[src] = '0;
    do begin
      best = -1;
      progress = 1'b0;
      for (int i = 0; i < n; i++)
        if (!settled[i] && (best < 0 || cost[i] < cost[best])) best = i;
      if (best >= 0 && cost[best] != COST_INF) begin
        progress = 1'b1;
        settled[best] = 1'b1;
        for (int k = 0; k < link_count; k++) begin
          if (link_tail[k] == best && link_head[k] < n) begin
            sum = {1'b0, cost[best]} + link_weight[k];
            if (sum > COST_INF) sum = COST_INF;
            if (sum < cost[link_head[k]]) cost[link_head[k]] = sum[COST_BITS-1:0];
          end
        end
      end
    end while (progress);
    for (int i = 0; i < n; i++)
      if (cost[i] <= thr) hits++;
    return NODE_CNT_BITS'(hits);
  endfunction

  function automatic bit take_gap();
    return !quiet && ($urandom_range(99) < 8);
  endfunction

  function automatic in_item_t make_item(
    input logic [1:0] cmd, input logic [NODE_BITS-1:0] tail, input logic [NODE_BITS-1:0] head,
    input logic [WEIGHT_FIELD_BITS-1:0] wt, input logic [NODE_BITS-1:0] src,
    input logic [THRESHOLD_BITS-1:0] thr);
    in_item_t it;
    it.command     = cmd;
    it.edge_from   = tail;
    it.edge_to     = head;
    it.edge_weight = wt;
    it.source_node = src;
    it.threshold   = thr;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_item(input in_item_t it);
    item_q = {item_q, it};
    pushed_total++;
    if (it.command != CMD_UNUSED) stim_count++;
  endtask

  // block is idle: every item taken, every search reported, add/clear settled
  task automatic wait_idle();
    while (item_q.size() != 0 || accepted_total != pushed_total || reach_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_nodes(input logic [NODE_CNT_BITS-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    node_limit = value;
  endtask

  // one load-and-search sequence; span bounds the node indices mostly used
  task automatic run_phase(input int span, input int adds, input int runs, input bit wipe);
    logic [63:0] raw;
    in_item_t    it;
    int          add_left;
    int          run_left;
    add_left = adds;
    run_left = runs;
    if (wipe) queue_item(make_item(CMD_CLEAR, '0, '0, '0, '0, '0));
    while (add_left + run_left > 0) begin
      raw = {$urandom(), $urandom()};
      it  = raw[$bits(in_item_t)-1:0];
      if ($urandom_range(99) < 3) begin
        it.command = CMD_UNUSED;
      end else if (adds < 100 && $urandom_range(99) < 2) begin
        it.command = CMD_CLEAR;
      end else if (run_left > 0 &&
                   (add_left == 0 || (2 * add_left < adds && $urandom_range(2) == 0))) begin
        it.command = CMD_RUN;
        if ($urandom_range(9) != 0) it.source_node = NODE_BITS'($urandom_range(span - 1));
        case ($urandom_range(7))
          0:       it.threshold = '0;
          1:       it.threshold = '1;
          2, 3:    it.threshold = THRESHOLD_BITS'($urandom_range(40));
          4, 5:    it.threshold = THRESHOLD_BITS'($urandom_range(200000));
          default: ;
        endcase
        run_left--;
      end else begin
        it.command = CMD_ADD;
        // a tenth keep fully random ends, mostly refused on small graphs
        if ($urandom_range(9) != 0) begin
          it.edge_from = NODE_BITS'($urandom_range(span - 1));
          it.edge_to   = NODE_BITS'($urandom_range(span - 1));
        end
        case ($urandom_range(7))
          0:       it.edge_weight = '0;
          1:       it.edge_weight = '1;
          2, 3:    it.edge_weight = WEIGHT_FIELD_BITS'($urandom_range(15));
          default: ;
        endcase
        add_left--;
      end
      queue_item(it);
    end
  endtask

  // driver: new transfer only once the previous one went through
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_done) begin
        if (item_q.size() != 0 && !take_gap()) begin
          in_valid <= 1'b1;
          in_data  <= item_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= take_gap();
    end
  end

  // monitor: check results, then fold accepted items into the predictor
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_done <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (reach_q.size() == 0) begin
          report_mismatch($sformatf("result with no search pending: count %0d dropped %0b",
                                    out_data.reached_count, out_data.edges_dropped));
        end else begin
          want = reach_q.pop_front();
          if (out_data.reached_count !== want.reached_count)
            report_mismatch($sformatf("reached_count got %0d want %0d",
                                      out_data.reached_count, want.reached_count));
          if (out_data.edges_dropped !== want.edges_dropped)
            report_mismatch($sformatf("edges_dropped got %0b want %0b",
                                      out_data.edges_dropped, want.edges_dropped));
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.command)
          CMD_CLEAR: begin
            link_count = 0;
            drop_seen  = 1'b0;
          end
          CMD_ADD: begin
            if (link_count >= LINK_CAP || in_data.edge_from >= active_node_count() ||
                in_data.edge_to >= active_node_count()) begin
              drop_seen = 1'b1;
            end else begin
              link_tail[link_count]   = in_data.edge_from;
              link_head[link_count]   = in_data.edge_to;
              link_weight[link_count] = in_data.edge_weight;
              link_count++;
            end
          end
          CMD_RUN: begin
            want.reached_count = count_reached(in_data.source_node, in_data.threshold);
            want.edges_dropped = drop_seen;
            reach_q = {reach_q, want};
          end
          default: ;
        endcase
        accepted_total++;
      end
    end
  end

  initial begin : stimulus
    int n;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, 64 nodes from reset: empty store, extreme fields, unused command
    queue_item(make_item(CMD_RUN, '0, '0, '0, '0, '0));
    queue_item(make_item(CMD_RUN, '0, '0, '0, '1, '1));
    queue_item(make_item(CMD_ADD, '0, '1, '1, '0, '0));
    queue_item(make_item(CMD_ADD, '1, 6'd5, '0, '0, '0));
    queue_item(make_item(CMD_ADD, 6'd5, '1, 16'd1, '0, '0));
    queue_item(make_item(CMD_ADD, '1, '0, '0, '0, '0));
    queue_item(make_item(CMD_UNUSED, '1, '1, '1, '1, '1));
    queue_item(make_item(CMD_RUN, '0, '0, '0, '0, 22'd65534));
    queue_item(make_item(CMD_RUN, '0, '0, '0, '0, 22'd65535));
    queue_item(make_item(CMD_RUN, '0, '0, '0, '1, '0));
    queue_item(make_item(CMD_RUN, '0, '0, '0, 6'd5, '1));
    queue_item(make_item(CMD_CLEAR, '1, '1, '1, '1, '1));
    queue_item(make_item(CMD_RUN, '0, '0, '0, '0, '1));
    wait_idle();

    // single node, and zero acting as one
    write_nodes(7'd1);
    run_phase(1, 4, 4, 1'b1);
    wait_idle();
    write_nodes(7'd0);
    run_phase(1, 3, 3, 1'b1);
    wait_idle();

    // load on 16 nodes, then shrink to 5 keeping the store
    write_nodes(7'd16);
    run_phase(16, 30, 10, 1'b1);
    wait_idle();
    write_nodes(7'd5);
    run_phase(5, 6, 8, 1'b0);
    wait_idle();

    // oversized count acts as 64; fill the store past capacity with no gaps
    write_nodes(7'd127);
    quiet = 1'b1;
    run_phase(64, LINK_CAP + 14, 3, 1'b1);
    wait_idle();
    quiet = 1'b0;

    write_nodes(7'd65);
    run_phase(64, 40, 6, 1'b1);
    wait_idle();

    while (stim_count < 550) begin
      n = $urandom_range(2, 12);
      write_nodes(NODE_CNT_BITS'(n));
      run_phase(n, $urandom_range(4, 3 * n), $urandom_range(3, 8), $urandom_range(3) != 0);
      wait_idle();
    end

    repeat (40) @(negedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
